>>> design/sorted_range_bounds_search_top_defines.svh
// Assertion macros shared by the sorted range bounds search checker.
// Depends on clk and rst being visible where the macros are used.
`ifndef SORTED_RANGE_BOUNDS_SEARCH_TOP_DEFINES_SVH
`define SORTED_RANGE_BOUNDS_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SRBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srbs assertion failed");

// Next-cycle implication, disabled in reset
`define SRBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srbs assertion failed");

`endif

>>> design/srbs_pkg.sv
// Shared types and constants for the sorted range bounds search block.
// No dependencies.
`timescale 1ns / 1ps

package srbs_pkg;

  localparam int DATA_W = 32;
  localparam int OUT_IDX_W = 10;
  localparam int ACT_W = 2;

  // Command codes
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // Search status handed back to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } srch_stat_t;

  // Search answer, indices already cut to the output width
  typedef struct packed {
    logic found;
    logic [OUT_IDX_W-1:0] first_idx;
    logic [OUT_IDX_W-1:0] last_idx;
  } srch_res_t;

endpackage

>>> design/srbs_store.sv
// Element store: single write port, one registered read port.
// Depends on srbs_pkg for the data width.
`timescale 1ns / 1ps

module srbs_store #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic [srbs_pkg::DATA_W-1:0]     wdata,
  input  logic [AW-1:0]                   raddr,
  output logic [srbs_pkg::DATA_W-1:0]     rdata
);

  logic [srbs_pkg::DATA_W-1:0] mem [DEPTH];

  // Write appended word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/srbs_search.sv
// Sequencer for the two bound searches sharing one compare unit and the
// store read port. Depends on srbs_pkg for types and widths.
`timescale 1ns / 1ps

module srbs_search #(
  parameter int AW = 10,
  parameter int CW = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [srbs_pkg::DATA_W-1:0]  key_in,
  input  logic [CW-1:0]                       count,
  output logic [AW-1:0]                       raddr,
  input  logic [srbs_pkg::DATA_W-1:0]         rdata,
  output srbs_pkg::srch_stat_t                stat,
  output srbs_pkg::srch_res_t                 res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam int XW = AW + srbs_pkg::OUT_IDX_W;

  logic [1:0] state;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi_ex;
  logic [AW-1:0] mid;
  logic pass;
  logic signed [srbs_pkg::DATA_W-1:0] key;
  logic first_hit;
  logic last_hit;
  logic [AW-1:0] first_idx;
  logic [AW-1:0] last_idx;
  logic done;

  logic [CW:0] sum_load;
  logic [AW-1:0] mid_load;
  logic eq;
  logic lt;
  logic [CW-1:0] lo_next;
  logic [CW-1:0] hi_ex_next;
  logic [CW:0] sum_next;
  logic [AW-1:0] mid_next;
  logic [XW-1:0] first_ext;
  logic [XW-1:0] last_ext;

  // Floor midpoint of the current window (hi_ex is one past the top)
  always_comb begin
    sum_load = (CW + 1)'(lo) + (CW + 1)'(hi_ex) - (CW + 1)'(1);
    mid_load = AW'(sum_load >> 1);
  end

  // Compare fetched element and narrow the window
  always_comb begin
    eq = ($signed(rdata) == key);
    lt = ($signed(rdata) < key);
    lo_next = lo;
    hi_ex_next = hi_ex;
    if (eq) begin
      if (pass) begin
        lo_next = CW'(mid) + CW'(1);
      end else begin
        hi_ex_next = CW'(mid);
      end
    end else if (lt) begin
      lo_next = CW'(mid) + CW'(1);
    end else begin
      hi_ex_next = CW'(mid);
    end
    sum_next = (CW + 1)'(lo_next) + (CW + 1)'(hi_ex_next) - (CW + 1)'(1);
    mid_next = AW'(sum_next >> 1);
  end

  // Read address: next midpoint while comparing, else window midpoint
  assign raddr = (state == ST_CMP) ? mid_next : mid_load;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
      pass <= 1'b0;
      first_hit <= 1'b0;
      last_hit <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            key <= key_in;
            lo <= '0;
            hi_ex <= count;
            pass <= 1'b0;
            first_hit <= 1'b0;
            last_hit <= 1'b0;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (lo < hi_ex) begin
            mid <= mid_load;
            state <= ST_CMP;
            done <= 1'b0;
          end else if (!pass) begin
            pass <= 1'b1;
            lo <= '0;
            hi_ex <= count;
            done <= 1'b0;
          end else begin
            state <= ST_IDLE;
            done <= 1'b1;
          end
        end
        ST_CMP: begin
          if (eq) begin
            if (pass) begin
              last_hit <= 1'b1;
              last_idx <= mid;
            end else begin
              first_hit <= 1'b1;
              first_idx <= mid;
            end
          end
          if (lo_next < hi_ex_next) begin
            lo <= lo_next;
            hi_ex <= hi_ex_next;
            mid <= mid_next;
            done <= 1'b0;
          end else if (!pass) begin
            pass <= 1'b1;
            lo <= '0;
            hi_ex <= count;
            state <= ST_LOAD;
            done <= 1'b0;
          end else begin
            state <= ST_IDLE;
            done <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          done <= 1'b0;
        end
      endcase
    end
  end

  // Cut indices to the output width, zero when no match
  always_comb begin
    first_ext = XW'(first_idx);
    last_ext = XW'(last_idx);
    res.found = first_hit;
    res.first_idx = first_hit ? first_ext[srbs_pkg::OUT_IDX_W-1:0] : '0;
    res.last_idx = last_hit ? last_ext[srbs_pkg::OUT_IDX_W-1:0] : '0;
    stat.busy = (state != ST_IDLE);
    stat.done = done;
  end

endmodule

>>> design/sorted_range_bounds_search_top.sv
// Query: two bound searches, each step one store read and one signed compare.
// Append and clear leave busy low; unused actions are dropped.
// One result word per query, strobed by done for one cycle.
// Synchronous reset empties the store and clears the overflow flag.
// Top level: command decode, element count, overflow flag. Uses srbs_pkg,
// srbs_store and srbs_search.
`timescale 1ns / 1ps

module sorted_range_bounds_search_top #(
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  output logic                                        busy,
  input  logic [srbs_pkg::ACT_W-1:0]                  action,
  input  logic signed [srbs_pkg::DATA_W-1:0]          item_value,
  output logic                                        done,
  output logic                                        found,
  output logic [srbs_pkg::OUT_IDX_W-1:0]              first_index,
  output logic [srbs_pkg::OUT_IDX_W-1:0]              last_index,
  output logic                                        store_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic overflow;
  logic accept;
  logic do_write;
  logic [AW-1:0] raddr;
  logic [srbs_pkg::DATA_W-1:0] rdata;
  srbs_pkg::srch_stat_t stat;
  srbs_pkg::srch_res_t res;

  assign accept = start && !stat.busy;
  assign do_write = accept && (action == srbs_pkg::ACT_APPEND) && (count < CW'(DEPTH));

  // Track element count and dropped appends
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      case (action)
        srbs_pkg::ACT_APPEND: begin
          if (count < CW'(DEPTH)) begin
            count <= count + CW'(1);
          end else begin
            overflow <= 1'b1;
          end
        end
        srbs_pkg::ACT_CLEAR: begin
          count <= '0;
          overflow <= 1'b0;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  srbs_store #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .we(do_write),
    .waddr(count[AW-1:0]),
    .wdata(item_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  srbs_search #(
    .AW(AW),
    .CW(CW)
  ) u_search (
    .clk(clk),
    .rst(rst),
    .start(accept && (action == srbs_pkg::ACT_QUERY)),
    .key_in(item_value),
    .count(count),
    .raddr(raddr),
    .rdata(rdata),
    .stat(stat),
    .res(res)
  );

  // Drive result word
  assign busy = stat.busy;
  assign done = stat.done;
  assign found = res.found;
  assign first_index = res.first_idx;
  assign last_index = res.last_idx;
  assign store_full = overflow;

endmodule

>>> design/srbs_checker.sv
// Port-level checker for the sorted range bounds search top level, bound in.
// Depends on srbs_pkg and sorted_range_bounds_search_top_defines.svh.
`timescale 1ns / 1ps
`include "sorted_range_bounds_search_top_defines.svh"

module srbs_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [srbs_pkg::ACT_W-1:0]          action,
  input logic                                done,
  input logic                                found,
  input logic [srbs_pkg::OUT_IDX_W-1:0]      first_index,
  input logic [srbs_pkg::OUT_IDX_W-1:0]      last_index
);

  // A query word makes the block busy
  `SRBS_ASSERT_NXT(a_query_busy, start && !busy && action == srbs_pkg::ACT_QUERY, busy)
  // A result ends a busy stretch
  `SRBS_ASSERT_IMP(a_done_after_busy, done, $past(busy) && !busy)
  // Result strobe lasts one cycle
  `SRBS_ASSERT_NXT(a_done_pulse, done, !done)
  // A miss reports zero indices
  `SRBS_ASSERT_IMP(a_miss_zero, done && !found, first_index == '0 && last_index == '0)

endmodule

bind sorted_range_bounds_search_top srbs_checker u_srbs_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .action(action),
  .done(done),
  .found(found),
  .first_index(first_index),
  .last_index(last_index)
);

>>> verif/tb.sv
// Self-checking testbench for sorted_range_bounds_search_top: appends, clears and
// bound queries on the element store, checked against a cycle-free shadow search.
// Depends on srbs_pkg and the design sources only.
`timescale 1ns / 1ps

module tb;

  localparam int STORE_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 30;
  localparam int WORD_TARGET = 1100;
  localparam logic [srbs_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -I32_MAX - 1;

  // One pending command word, or a marker that holds the sender until drained
  typedef struct {
    logic [srbs_pkg::ACT_W-1:0] act;
    logic signed [srbs_pkg::DATA_W-1:0] val;
    bit drain;
  } cmd_t;

  // Expected answer of one query
  typedef struct {
    logic found;
    logic [srbs_pkg::OUT_IDX_W-1:0] first_idx;
    logic [srbs_pkg::OUT_IDX_W-1:0] last_idx;
    logic full;
  } bounds_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [srbs_pkg::ACT_W-1:0] action;
  logic signed [srbs_pkg::DATA_W-1:0] item_value;
  logic done;
  logic found;
  logic [srbs_pkg::OUT_IDX_W-1:0] first_index;
  logic [srbs_pkg::OUT_IDX_W-1:0] last_index;
  logic store_full;

  cmd_t cmd_q[$];
  bounds_t pending_bounds[$];

  // Shadow copy of the block state
  logic signed [srbs_pkg::DATA_W-1:0] shadow_mem [STORE_DEPTH];
  int shadow_count;
  bit shadow_full;

  int sent_cnt;
  int taken_cnt;
  int err_cnt;
  int cyc;
  int rand_words;
  bit holding;

  sorted_range_bounds_search_top #(
    .DEPTH(STORE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .item_value(item_value),
    .done(done),
    .found(found),
    .first_index(first_index),
    .last_index(last_index),
    .store_full(store_full)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hold reset high, release it on a falling edge
  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic longint clamp32(input longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  // Floor-midpoint binary search; go_right keeps moving right after a match
  function automatic int bound_scan(input logic signed [srbs_pkg::DATA_W-1:0] key,
                                    input bit go_right);
    int lo;
    int hi;
    int mid;
    int hit;
    lo = 0;
    hi = shadow_count - 1;
    hit = -1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_mem[mid] == key) begin
        hit = mid;
        if (go_right) lo = mid + 1;
        else hi = mid - 1;
      end else if (shadow_mem[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return hit;
  endfunction

  // Advance the shadow state by one accepted word; queue the answer of a query
  function automatic void apply_word(input logic [srbs_pkg::ACT_W-1:0] act,
                                     input logic signed [srbs_pkg::DATA_W-1:0] val);
    bounds_t ans;
    int first_hit;
    int last_hit;
    case (act)
      srbs_pkg::ACT_APPEND: begin
        if (shadow_count < STORE_DEPTH) begin
          shadow_mem[shadow_count] = val;
          shadow_count++;
        end else begin
          shadow_full = 1'b1;
        end
      end
      srbs_pkg::ACT_CLEAR: begin
        shadow_count = 0;
        shadow_full = 1'b0;
      end
      srbs_pkg::ACT_QUERY: begin
        first_hit = bound_scan(val, 1'b0);
        last_hit = bound_scan(val, 1'b1);
        ans.found = (first_hit >= 0);
        ans.first_idx = (first_hit >= 0) ? first_hit[srbs_pkg::OUT_IDX_W-1:0] : '0;
        ans.last_idx = (last_hit >= 0) ? last_hit[srbs_pkg::OUT_IDX_W-1:0] : '0;
        ans.full = shadow_full;
        pending_bounds.push_back(ans);
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Sample at the rising edge: check strobed results, then log accepted words
  always @(posedge clk) begin
    bounds_t want;
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending_bounds.size() == 0) begin
          err_cnt++;
          $display("%0t: result with no query waiting, expected none, actual %b %0d %0d %b",
                   $time, found, first_index, last_index, store_full);
        end else begin
          want = pending_bounds.pop_front();
          check_field("found", 32'(want.found), 32'(found));
          check_field("first_index", 32'(want.first_idx), 32'(first_index));
          check_field("last_index", 32'(want.last_idx), 32'(last_index));
          check_field("store_full", 32'(want.full), 32'(store_full));
        end
      end
      if (start && !busy) begin
        apply_word(action, item_value);
        taken_cnt++;
      end
    end
  end

  // Drive at the falling edge: hold an untaken word, else present the next or idle
  always @(negedge clk) begin
    cmd_t nx;
    int idle_pct;
    if (rst) begin
      start <= 1'b0;
      action <= srbs_pkg::ACT_APPEND;
      item_value <= '0;
    end else if (!(start && taken_cnt != sent_cnt)) begin
      idle_pct = (taken_cnt >= 300 && taken_cnt < 600) ? 0 : 34;
      while (cmd_q.size() > 0 && cmd_q[0].drain) begin
        void'(cmd_q.pop_front());
        holding = 1'b1;
      end
      if (holding && pending_bounds.size() == 0) holding = 1'b0;
      if (!holding && cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        nx = cmd_q.pop_front();
        start <= 1'b1;
        action <= nx.act;
        item_value <= nx.val;
        sent_cnt++;
      end else begin
        start <= 1'b0;
        action <= srbs_pkg::ACT_W'($urandom);
        item_value <= $urandom;
      end
    end
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_cmd(input logic [srbs_pkg::ACT_W-1:0] act, input longint val,
                          input bit drain = 1'b0);
    cmd_t c;
    c.act = act;
    c.val = val[srbs_pkg::DATA_W-1:0];
    c.drain = drain;
    cmd_q.push_back(c);
    if (!drain && act != ACT_UNUSED) rand_words++;
  endtask

  // Clear, append n ascending elements, then query around them
  task automatic sorted_run(input int n, input int spread, input int nq);
    longint vals[$];
    longint v;
    longint key;
    int kept;
    kept = (n < STORE_DEPTH) ? n : STORE_DEPTH;
    push_cmd(srbs_pkg::ACT_CLEAR, longint'($signed($urandom)));
    case ($urandom_range(0, 3))
      0: v = I32_MIN;
      1: v = I32_MAX - longint'(n) * spread / 2;
      2: v = longint'($urandom_range(0, 20)) - 10;
      default: v = longint'($signed($urandom));
    endcase
    v = clamp32(v);
    for (int i = 0; i < n; i++) begin
      vals.push_back(v);
      push_cmd(srbs_pkg::ACT_APPEND, v);
      v = clamp32(v + longint'($urandom_range(0, spread)));
    end
    for (int q = 0; q < nq; q++) begin
      if (kept > 0 && q == 0) key = vals[kept-1];
      else if (kept > 0 && q == 1) key = vals[0];
      else begin
        case ($urandom_range(0, 7))
          0: key = longint'($signed($urandom));
          1: key = I32_MIN;
          2: key = I32_MAX;
          default: begin
            if (n > 0)
              key = clamp32(vals[$urandom_range(0, n-1)]
                            + longint'($urandom_range(0, 4)) - 2);
            else
              key = longint'($urandom_range(0, 20)) - 10;
          end
        endcase
      end
      push_cmd(srbs_pkg::ACT_QUERY, key);
    end
    if ($urandom_range(0, 9) == 0) push_cmd(srbs_pkg::ACT_APPEND, 0, 1'b1);
  endtask

  initial begin
    int r;
    int k;
    int n;
    int spread;

    // Directed: empty store, ignored action, extremes and duplicates
    push_cmd(srbs_pkg::ACT_QUERY, 0);
    push_cmd(ACT_UNUSED, -1);
    push_cmd(srbs_pkg::ACT_APPEND, I32_MIN);
    push_cmd(srbs_pkg::ACT_APPEND, I32_MIN);
    push_cmd(srbs_pkg::ACT_APPEND, -1);
    push_cmd(srbs_pkg::ACT_APPEND, 0);
    push_cmd(srbs_pkg::ACT_APPEND, 5);
    push_cmd(srbs_pkg::ACT_APPEND, 5);
    push_cmd(srbs_pkg::ACT_APPEND, 5);
    push_cmd(srbs_pkg::ACT_APPEND, I32_MAX);
    push_cmd(srbs_pkg::ACT_QUERY, I32_MIN);
    push_cmd(srbs_pkg::ACT_QUERY, 5);
    push_cmd(srbs_pkg::ACT_QUERY, I32_MAX);
    push_cmd(srbs_pkg::ACT_APPEND, 0, 1'b1);
    push_cmd(srbs_pkg::ACT_QUERY, 3);
    push_cmd(srbs_pkg::ACT_QUERY, -1);
    push_cmd(srbs_pkg::ACT_QUERY, I32_MAX - 1);
    push_cmd(ACT_UNUSED, 5);
    push_cmd(srbs_pkg::ACT_QUERY, 5);
    // Clear empties the store
    push_cmd(srbs_pkg::ACT_CLEAR, 0);
    push_cmd(srbs_pkg::ACT_QUERY, 5);
    // Unsorted store
    push_cmd(srbs_pkg::ACT_APPEND, 9);
    push_cmd(srbs_pkg::ACT_APPEND, 1);
    push_cmd(srbs_pkg::ACT_APPEND, 7);
    push_cmd(srbs_pkg::ACT_QUERY, 1);
    push_cmd(srbs_pkg::ACT_QUERY, 7);

    // Fill to capacity and push a few appends past it
    sorted_run(STORE_DEPTH + 6, 1000, 12);
    push_cmd(srbs_pkg::ACT_APPEND, 0, 1'b1);

    // Random: mostly sorted runs, some queries, unsorted appends and noise
    while (rand_words < WORD_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(0, 40);
        case ($urandom_range(0, 3))
          0: spread = 2;
          1: spread = 50;
          2: spread = 1 << 20;
          default: spread = 1 << 28;
        endcase
        sorted_run(n, spread, $urandom_range(1, 10));
      end else if (r < 72) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          push_cmd(srbs_pkg::ACT_QUERY,
                   ($urandom_range(0, 1) == 1) ? longint'($signed($urandom))
                                               : longint'($urandom_range(0, 20)) - 10);
      end else if (r < 84) begin
        k = $urandom_range(1, 5);
        for (int i = 0; i < k; i++)
          push_cmd(srbs_pkg::ACT_APPEND, longint'($urandom_range(0, 20)) - 10);
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
          push_cmd(srbs_pkg::ACT_QUERY, longint'($urandom_range(0, 20)) - 10);
      end else if (r < 92) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
          push_cmd(ACT_UNUSED, longint'($signed($urandom)));
        push_cmd(srbs_pkg::ACT_QUERY, longint'($urandom_range(0, 20)) - 10);
      end else begin
        push_cmd(srbs_pkg::ACT_CLEAR, longint'($signed($urandom)));
        push_cmd(srbs_pkg::ACT_QUERY, longint'($signed($urandom)));
        push_cmd(srbs_pkg::ACT_APPEND, 0, 1'b1);
      end
    end

    // Drain: every word taken, every result in, then a short tail
    while (cmd_q.size() != 0 || taken_cnt != sent_cnt) @(posedge clk);
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/srbs_pkg.sv
design/srbs_store.sv
design/srbs_search.sv
design/sorted_range_bounds_search_top.sv
design/srbs_checker.sv
verif/tb.sv
